// ----- hw/rtl/tsr_pkg.sv -----
// Shared constants, types and helpers for the repeat-wrap texture sampler.
// No dependencies.
package tsr_pkg;

    localparam int ADDR_W = 16;
    localparam int DEPTH = 65536;
    localparam int FRAC_W = 16;
    localparam int DIM_W = 9;
    localparam int TEXEL_W = 32;
    localparam int COORD_W = 32;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_NEAREST = 2'd1;
    localparam logic [1:0] MODE_BILINEAR = 2'd2;

    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] DIM_MAX = 9'd256;

    // Per-item control that travels down the pipeline.
    typedef struct packed {
        logic                vld;
        logic                bilinear;
    } ctl_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_MAX)
            r = DIM_MAX;
        return r;
    endfunction

    // Fraction of the magnitude: low bits of c, or of its two's complement negation if negative.
    function automatic logic [FRAC_W-1:0] frac_mag(input logic [COORD_W-1:0] c);
        logic [FRAC_W-1:0] lo;
        lo = c[FRAC_W-1:0];
        return c[COORD_W-1] ? FRAC_W'(~lo + 1'b1) : lo;
    endfunction

endpackage

// ----- hw/rtl/texture_sampler_repeat_unit.sv -----
// Top level of the repeat-wrap texture sampler: config, texel RAM banks, pipeline.
// Depends on tsr_pkg, tsr_ram, tsr_addr, tsr_blend.
//
//  channel  signals                                         direction
//  in       in_valid/in_stall, mode, texel_address, ...     request in
//  out      out_valid/out_stall, color                      request out
//  cfg      cfg_we, cfg_index, cfg_data                     write only
//
// One request per cycle unless the pipeline is stalled.
// Four RAM copies, written together, give four neighbor reads per unstalled cycle.
// Writes reach the RAMs two stages after acceptance, in line with sample reads.
// A stall freezes the whole pipeline; in_stall follows out_stall while a result waits.
// Reset clears valid bits, sets sizes to 256; texel RAM is undefined until written.
module texture_sampler_repeat_unit
    import tsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic [ADDR_W-1:0]    texel_address,
    input  logic [TEXEL_W-1:0]   texel_data,
    input  logic signed [COORD_W-1:0] coord_u,
    input  logic signed [COORD_W-1:0] coord_v,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [TEXEL_W-1:0]   color,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    logic [DIM_W-1:0]   w_reg, h_reg;
    logic               en;
    ctl_t               ctl_in, ctl_a, ctl_r, ctl_b;
    logic [ADDR_W-1:0]  a_tl, a_tr, a_bl, a_br;
    logic [FRAC_W-1:0]  xf, yf, xf_reg, yf_reg;
    logic [TEXEL_W-1:0] t_tl, t_tr, t_bl, t_br;
    logic               wr;
    logic               wr1_reg, wr2_reg;
    logic [ADDR_W-1:0]  wa1_reg, wa2_reg;
    logic [TEXEL_W-1:0] wd1_reg, wd2_reg;

    assign en = !(ctl_b.vld && out_stall);
    assign in_stall = !en;
    assign wr = wr2_reg && en;
    assign ctl_in.vld = in_valid && (mode == MODE_NEAREST || mode == MODE_BILINEAR);
    assign ctl_in.bilinear = (mode == MODE_BILINEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= DIM_MAX;
            h_reg <= DIM_MAX;
            ctl_r <= '0;
            wr1_reg <= 1'b0;
            wr2_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_WIDTH)
                w_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_HEIGHT)
                h_reg <= cfg_data;
            if (en)
            begin
                ctl_r <= ctl_a;
                wr1_reg <= in_valid && (mode == MODE_WRITE);
                wr2_reg <= wr1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xf_reg <= xf;
            yf_reg <= yf;
            wa1_reg <= texel_address;
            wd1_reg <= texel_data;
            wa2_reg <= wa1_reg;
            wd2_reg <= wd1_reg;
        end
    end

    tsr_addr u_addr (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_in),
        .coord_u (coord_u),
        .coord_v (coord_v),
        .dim_w   (clamp_dim(w_reg)),
        .dim_h   (clamp_dim(h_reg)),
        .ctl_out (ctl_a),
        .addr_tl (a_tl),
        .addr_tr (a_tr),
        .addr_bl (a_bl),
        .addr_br (a_br),
        .xf      (xf),
        .yf      (yf)
    );

    tsr_ram #(.WIDTH(TEXEL_W), .DEPTH(DEPTH)) u_ram_tl (
        .clk(clk), .we(wr), .waddr(wa2_reg), .wdata(wd2_reg),
        .re(en), .raddr(a_tl), .rdata(t_tl));
    tsr_ram #(.WIDTH(TEXEL_W), .DEPTH(DEPTH)) u_ram_tr (
        .clk(clk), .we(wr), .waddr(wa2_reg), .wdata(wd2_reg),
        .re(en), .raddr(a_tr), .rdata(t_tr));
    tsr_ram #(.WIDTH(TEXEL_W), .DEPTH(DEPTH)) u_ram_bl (
        .clk(clk), .we(wr), .waddr(wa2_reg), .wdata(wd2_reg),
        .re(en), .raddr(a_bl), .rdata(t_bl));
    tsr_ram #(.WIDTH(TEXEL_W), .DEPTH(DEPTH)) u_ram_br (
        .clk(clk), .we(wr), .waddr(wa2_reg), .wdata(wd2_reg),
        .re(en), .raddr(a_br), .rdata(t_br));

    tsr_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_r),
        .t_tl    (t_tl),
        .t_tr    (t_tr),
        .t_bl    (t_bl),
        .t_br    (t_br),
        .xf      (xf_reg),
        .yf      (yf_reg),
        .ctl_out (ctl_b),
        .color   (color)
    );

    assign out_valid = ctl_b.vld;

endmodule

// ----- hw/rtl/tsr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/tsr_addr.sv -----
// Address stages: coordinate scaling and neighbor address generation.
// Depends on tsr_pkg.
module tsr_addr
    import tsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  ctl_t                 ctl_in,
    input  logic [COORD_W-1:0]   coord_u,
    input  logic [COORD_W-1:0]   coord_v,
    input  logic [DIM_W-1:0]     dim_w,
    input  logic [DIM_W-1:0]     dim_h,
    output ctl_t                 ctl_out,
    output logic [ADDR_W-1:0]    addr_tl,
    output logic [ADDR_W-1:0]    addr_tr,
    output logic [ADDR_W-1:0]    addr_bl,
    output logic [ADDR_W-1:0]    addr_br,
    output logic [FRAC_W-1:0]    xf,
    output logic [FRAC_W-1:0]    yf
);

    localparam int P_W = FRAC_W + DIM_W;

    ctl_t               ctl1_reg;
    logic [P_W-1:0]     px_reg, py_reg;
    logic [DIM_W-1:0]   w_reg;
    logic [DIM_W-1:0]   h_reg;
    ctl_t               ctl2_reg;
    logic [ADDR_W-1:0]  tl_reg, tr_reg, bl_reg, br_reg;
    logic [FRAC_W-1:0]  xf_reg, yf_reg;

    logic [DIM_W-1:0]   lx, ty, rx, by;
    logic [DIM_W-1:0]   lx_inc, ty_inc;
    logic [ADDR_W-1:0]  row_t, row_b;

    always_comb
    begin
        lx = px_reg[P_W-1:FRAC_W];
        ty = py_reg[P_W-1:FRAC_W];
        lx_inc = lx + 1'b1;
        ty_inc = ty + 1'b1;
        rx = (px_reg[FRAC_W-1:0] == '0) ? lx : ((lx_inc == w_reg) ? '0 : lx_inc);
        by = (py_reg[FRAC_W-1:0] == '0) ? ty : ((ty_inc == h_reg) ? '0 : ty_inc);
        row_t = ADDR_W'(ty) * ADDR_W'(w_reg);
        row_b = ADDR_W'(by) * ADDR_W'(w_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= P_W'(frac_mag(coord_u)) * P_W'(dim_w);
            py_reg <= P_W'(frac_mag(coord_v)) * P_W'(dim_h);
            w_reg  <= dim_w;
            h_reg  <= dim_h;
            tl_reg <= row_t + ADDR_W'(lx);
            tr_reg <= row_t + ADDR_W'(rx);
            bl_reg <= row_b + ADDR_W'(lx);
            br_reg <= row_b + ADDR_W'(rx);
            xf_reg <= px_reg[FRAC_W-1:0];
            yf_reg <= py_reg[FRAC_W-1:0];
        end
    end

    assign ctl_out = ctl2_reg;
    assign addr_tl = tl_reg;
    assign addr_tr = tr_reg;
    assign addr_bl = bl_reg;
    assign addr_br = br_reg;
    assign xf = xf_reg;
    assign yf = yf_reg;

endmodule

// ----- hw/rtl/tsr_blend.sv -----
// Blend stages: horizontal then vertical weighting of low three bytes.
// Depends on tsr_pkg.
module tsr_blend
    import tsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  ctl_t                 ctl_in,
    input  logic [TEXEL_W-1:0]   t_tl,
    input  logic [TEXEL_W-1:0]   t_tr,
    input  logic [TEXEL_W-1:0]   t_bl,
    input  logic [TEXEL_W-1:0]   t_br,
    input  logic [FRAC_W-1:0]    xf,
    input  logic [FRAC_W-1:0]    yf,
    output ctl_t                 ctl_out,
    output logic [TEXEL_W-1:0]   color
);

    localparam int H_W = FRAC_W + 8;
    localparam int ONE_W = FRAC_W + 1;
    localparam int S_W = H_W + ONE_W;
    localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_W;

    ctl_t               ctl1_reg, ctl2_reg;
    logic [H_W-1:0]     top_reg [3];
    logic [H_W-1:0]     bot_reg [3];
    logic [FRAC_W-1:0]  yf_reg;
    logic [TEXEL_W-1:0] near_reg, color_reg;
    logic [TEXEL_W-1:0] blend_next;
    logic [ONE_W-1:0]   xw;
    logic [ONE_W-1:0]   yw;

    assign xw = ONE - ONE_W'(xf);
    assign yw = ONE - ONE_W'(yf_reg);

    always_comb
    begin
        blend_next = '0;
        for (int c = 0; c < 3; c++)
            blend_next[c*8 +: 8] = 8'((S_W'(top_reg[c]) * S_W'(yw)
                + S_W'(bot_reg[c]) * S_W'(yf_reg)) >> (2 * FRAC_W));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                top_reg[c] <= H_W'(t_tl[c*8 +: 8]) * H_W'(xw)
                    + H_W'(t_tr[c*8 +: 8]) * H_W'(xf);
                bot_reg[c] <= H_W'(t_bl[c*8 +: 8]) * H_W'(xw)
                    + H_W'(t_br[c*8 +: 8]) * H_W'(xf);
            end
            yf_reg <= yf;
            near_reg <= t_tl;
            color_reg <= ctl1_reg.bilinear ? blend_next : near_reg;
        end
    end

    assign ctl_out = ctl2_reg;
    assign color = color_reg;

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for texture_sampler_repeat_unit: write, nearest and bilinear requests.
// Uses tsr_pkg and the RTL; predicts colors with its own texel memory model.
`timescale 1ns / 100ps

module testbench;
    import tsr_pkg::*;

    typedef struct {
        logic [1:0]  md;
        logic [15:0] addr;
        logic [31:0] data;
        logic [31:0] u;
        logic [31:0] v;
    } tex_req_t;

    localparam int WATCHDOG = 3000;
    localparam int LONG_HOLD = 400;
    localparam int FILL_TEXELS = 256;
    localparam logic [1:0] MODE_NONE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [15:0] texel_address;
    logic [31:0] texel_data;
    logic signed [31:0] coord_u;
    logic signed [31:0] coord_v;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] color;
    logic        cfg_we;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    tex_req_t    req_q[$];
    tex_req_t    cur_req;
    logic [31:0] color_q[$];
    logic [31:0] texel_mem[65536];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    int          errors;
    int          in_gap;
    int          out_gap;
    int          hold_cnt;
    int          idle_cycles;
    bit          quiet;
    bit          hold_go;
    bit          hold_done;

    texture_sampler_repeat_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .texel_address(texel_address), .texel_data(texel_data),
        .coord_u(coord_u), .coord_v(coord_v),
        .out_valid(out_valid), .out_stall(out_stall), .color(color),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int eff_dim(logic [8:0] d);
        if (d == 0)
            return 1;
        if (d > 256)
            return 256;
        return d;
    endfunction

    function automatic logic [15:0] coord_frac(logic [31:0] c);
        logic [31:0] m;
        m = c[31] ? (~c + 32'd1) : c;
        return m[15:0];
    endfunction

    function automatic logic [31:0] sample_color(logic bil, logic [31:0] u, logic [31:0] v);
        int w, h, lx, ty, rx, by;
        longint px, py, xf, yf, top, bot, c;
        logic [31:0] tl, tr, bl, br, res;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        px = longint'(coord_frac(u)) * w;
        py = longint'(coord_frac(v)) * h;
        lx = int'(px >> 16);
        ty = int'(py >> 16);
        xf = px & 16'hFFFF;
        yf = py & 16'hFFFF;
        if (!bil)
            return texel_mem[((lx % w) + (ty % h) * w) % 65536];
        rx = ((xf != 0) ? lx + 1 : lx) % w;
        by = ((yf != 0) ? ty + 1 : ty) % h;
        tl = texel_mem[(lx + ty * w) % 65536];
        tr = texel_mem[(rx + ty * w) % 65536];
        bl = texel_mem[(lx + by * w) % 65536];
        br = texel_mem[(rx + by * w) % 65536];
        res = 0;
        for (int sh = 0; sh <= 16; sh += 8)
        begin
            top = longint'((tl >> sh) & 8'hFF) * (65536 - xf) + longint'((tr >> sh) & 8'hFF) * xf;
            bot = longint'((bl >> sh) & 8'hFF) * (65536 - xf) + longint'((br >> sh) & 8'hFF) * xf;
            c = (top * (65536 - yf) + bot * yf) >> 32;
            res |= (32'(c) & 32'hFF) << sh;
        end
        return res;
    endfunction

    function automatic tex_req_t make_req(logic [1:0] md, logic [15:0] a, logic [31:0] d,
                                          logic [31:0] u, logic [31:0] v);
        tex_req_t r;
        r.md = md;
        r.addr = a;
        r.data = d;
        r.u = u;
        r.v = v;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return {16'($urandom_range(0, 65535)), 16'h0};
            3: return 32'($urandom_range(0, 131071)) - 32'd65536;
            default: return $urandom;
        endcase
    endfunction

    // driver: present requests, predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (cur_req.md == MODE_WRITE)
                    texel_mem[cur_req.addr] = cur_req.data;
                else if (cur_req.md == MODE_NEAREST || cur_req.md == MODE_BILINEAR)
                    color_q.push_back(sample_color(cur_req.md == MODE_BILINEAR,
                                                   cur_req.u, cur_req.v));
            end
            if (!(in_valid && in_stall))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (req_q.size() > 0)
                begin
                    cur_req = req_q.pop_front();
                    in_valid <= 1'b1;
                    mode <= cur_req.md;
                    texel_address <= cur_req.addr;
                    texel_data <= cur_req.data;
                    coord_u <= cur_req.u;
                    coord_v <= cur_req.v;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        in_gap = $urandom_range(1, 13);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: stall pattern and color check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (color_q.size() == 0)
                begin
                    $display("%0t: color expected nothing actual %h", $time, color);
                    errors++;
                end
                else
                begin
                    if (color !== color_q[0])
                    begin
                        $display("%0t: color expected %h actual %h", $time, color_q[0], color);
                        errors++;
                    end
                    void'(color_q.pop_front());
                end
            end
            if (hold_go && !hold_done)
            begin
                hold_done = 1;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 9) == 0)
                    out_gap = $urandom_range(1, 13);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic wait_drained();
        while (req_q.size() > 0 || in_valid || color_q.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_size(logic [8:0] w, logic [8:0] h);
        wait_drained();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data <= w;
        width_reg = w;
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data <= h;
        height_reg = h;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_random(int n);
        int r;
        logic [1:0] md;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 19);
            md = (r < 4) ? MODE_WRITE : (r < 11) ? MODE_NEAREST :
                 (r < 19) ? MODE_BILINEAR : MODE_NONE;
            req_q.push_back(make_req(md, 16'($urandom), $urandom, rand_coord(), rand_coord()));
        end
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        mode = MODE_WRITE;
        texel_address = 0;
        texel_data = 0;
        coord_u = 0;
        coord_v = 0;
        out_stall = 0;
        cfg_we = 0;
        cfg_index = CFG_WIDTH;
        cfg_data = 0;
        errors = 0;
        in_gap = 0;
        out_gap = 0;
        hold_cnt = 0;
        idle_cycles = 0;
        quiet = 0;
        hold_go = 0;
        hold_done = 0;
        width_reg = 256;
        height_reg = 256;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        set_size(9'd16, 9'd16);

        // fill the low texels; every size used below keeps width times height within them
        for (int a = 0; a < FILL_TEXELS; a++)
            req_q.push_back(make_req(MODE_WRITE, 16'(a), $urandom, 0, 0));

        req_q.push_back(make_req(MODE_WRITE, 16'h0000, 32'h0000_0000, 0, 0));
        req_q.push_back(make_req(MODE_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 0, 0));
        req_q.push_back(make_req(MODE_WRITE, 16'h0001, 32'h00FF_FFFF, 0, 0));
        req_q.push_back(make_req(MODE_WRITE, 16'h0010, 32'hFF80_40C0, 0, 0));
        req_q.push_back(make_req(MODE_NEAREST, 0, 0, 32'h0, 32'h0));
        req_q.push_back(make_req(MODE_NEAREST, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
        req_q.push_back(make_req(MODE_NEAREST, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_0001));
        req_q.push_back(make_req(MODE_BILINEAR, 0, 0, 32'h0, 32'h0));
        req_q.push_back(make_req(MODE_BILINEAR, 0, 0, 32'h0001_0000, 32'h0003_0000));
        req_q.push_back(make_req(MODE_BILINEAR, 0, 0, 32'h8000_0000, 32'h8000_0000));
        req_q.push_back(make_req(MODE_BILINEAR, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        req_q.push_back(make_req(MODE_BILINEAR, 0, 0, 32'h0000_0080, 32'hFFFF_FF80));
        req_q.push_back(make_req(MODE_BILINEAR, 0, 0, 32'h0000_FFFF, 32'h0000_8000));
        req_q.push_back(make_req(MODE_BILINEAR, 0, 0, 32'hFFFF_8000, 32'h0000_0001));
        req_q.push_back(make_req(MODE_NONE, 16'h1234, 32'hDEAD_BEEF, 32'h1234, 32'h5678));
        req_q.push_back(make_req(MODE_NEAREST, 0, 0, 32'h0000_4000, 32'h0000_C000));
        push_random(60);

        set_size(9'd1, 9'd1);
        push_random(30);
        hold_go = 1;
        push_random(60);
        set_size(9'd0, 9'd511);
        push_random(40);
        set_size(9'd511, 9'd0);
        push_random(40);
        set_size(9'd3, 9'd5);
        push_random(40);
        set_size(9'd256, 9'd1);
        push_random(40);
        set_size(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)));
        push_random(40);
        set_size(9'($urandom_range(0, 16)), 9'($urandom_range(0, 16)));
        quiet = 1;
        push_random(40);

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
